@@ sv/bttcm_pkg.sv @@
// Shared types and constants for the button to touch contact mapper.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package bttcm_pkg;

  localparam int ID_W       = 4;
  localparam int COUNT_W    = 4;
  localparam int COORD_W    = 14;
  localparam int XSTEP_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [COORD_W-1:0] COORD_MAX         = 14'd10000;
  localparam logic [COORD_W-1:0] HEIGHT_LOWER_RST  = 14'd9000;
  localparam logic [COORD_W-1:0] HEIGHT_CENTER_RST = 14'd5000;
  localparam logic [COORD_W-1:0] HEIGHT_UPPER_RST  = 14'd1000;
  localparam logic [XSTEP_W-1:0] X_STEP_RST        = 9'd344;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_LOWER,
    REG_HEIGHT_CENTER,
    REG_HEIGHT_UPPER,
    REG_X_STEP
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic pass1;
    logic pass2;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic stack_empty;
    logic slot_last;
    logic report_hold;
  } sts_t;

endpackage

@@ sv/bttcm_ctrl.sv @@
// Sequencing state machine: scan accept, release pass, assign pass, report walk.
// Depends on bttcm_pkg for the command and status structs.
`timescale 1ns / 1ps

module bttcm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            scan_valid,
  output logic            scan_stall,
  output bttcm_pkg::cmd_t cmd,
  input  bttcm_pkg::sts_t sts
);
  import bttcm_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    PASS1,
    PASS2,
    REPORT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (scan_valid) state <= PASS1;
        end
        PASS1: begin
          if (sts.idx_last) state <= PASS2;
        end
        PASS2: begin
          if (sts.stack_empty || sts.idx_last) state <= REPORT;
        end
        REPORT: begin
          if (sts.slot_last && !sts.report_hold) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign scan_stall = (state != IDLE);

  always_comb begin
    cmd.load   = (state == IDLE) && scan_valid;
    cmd.pass1  = (state == PASS1);
    cmd.pass2  = (state == PASS2);
    cmd.report = (state == REPORT);
  end

endmodule

@@ sv/bttcm_dp.sv @@
// Datapath: config registers, button owner memory, free id stack, contact table
// and the report output register. Depends on bttcm_pkg.
`timescale 1ns / 1ps

module bttcm_dp #(
  parameter int NUM_BUTTONS  = 28,
  parameter int MAX_CONTACTS = 10,
  parameter int SCAN_STRIDE  = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bttcm_pkg::cmd_t                     cmd,
  output bttcm_pkg::sts_t                     sts,
  input  logic [NUM_BUTTONS-1:0]              buttons,
  input  logic                                center_pin_low,
  input  logic                                upper_pin_low,
  input  logic                                wr_en,
  input  logic [bttcm_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [bttcm_pkg::CFG_DATA_W-1:0]    wr_data,
  output logic                                report_valid,
  input  logic                                report_stall,
  output logic [bttcm_pkg::COUNT_W-1:0]       contact_count,
  output logic [bttcm_pkg::ID_W-1:0]          touch_id,
  output logic                                tip_down,
  output logic [bttcm_pkg::COORD_W-1:0]       pos_x,
  output logic [bttcm_pkg::COORD_W-1:0]       pos_y,
  output logic                                last
);
  import bttcm_pkg::*;

  localparam int BTN_W    = $clog2(NUM_BUTTONS);
  localparam int SLOT_W   = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int CNT_W    = $clog2(MAX_CONTACTS + 1);
  localparam int STEP_MOD = SCAN_STRIDE % NUM_BUTTONS;
  localparam int XB_W     = $clog2(NUM_BUTTONS + 1);
  localparam int PROD_W   = (XB_W + XSTEP_W > COORD_W) ? XB_W + XSTEP_W : COORD_W;

  // configuration
  logic [COORD_W-1:0] height_lower, height_center, height_upper;
  logic [XSTEP_W-1:0] x_step;

  // per-scan latched inputs
  logic [NUM_BUTTONS-1:0] buttons_r;
  logic [COORD_W-1:0]     y_r;

  // walk counters
  logic [BTN_W-1:0]  idx;
  logic [BTN_W-1:0]  bsel;
  logic [BTN_W:0]    bsum;
  logic [SLOT_W-1:0] slot;

  // owner memory plus valid bits
  logic [ID_W-1:0]        owner_mem [NUM_BUTTONS];
  logic [ID_W-1:0]        owner_rdata;
  logic [BTN_W-1:0]       rd_addr;
  logic [NUM_BUTTONS-1:0] owner_vld;

  // free stack and contact table
  logic [ID_W-1:0]         free_stack [MAX_CONTACTS];
  logic [CNT_W-1:0]        free_count;
  logic [CNT_W-1:0]        pop_ptr;
  logic [MAX_CONTACTS-1:0] con;
  logic [MAX_CONTACTS-1:0] rsent;
  logic [COORD_W-1:0]      cx [MAX_CONTACTS];
  logic [COORD_W-1:0]      cy [MAX_CONTACTS];

  logic [COORD_W-1:0] y_sel, y_sat, x_sat;
  logic [BTN_W-1:0]   btn;
  logic [XB_W-1:0]    xb;
  logic [PROD_W-1:0]  prod;
  logic               held, pop;
  logic [ID_W-1:0]    pop_id;
  logic [MAX_CONTACTS-1:0] emit_vec;
  logic               emit_cur, more, out_busy, load_out;

  always_comb begin
    priority if (center_pin_low) y_sel = height_center;
    else if (upper_pin_low)      y_sel = height_upper;
    else                         y_sel = height_lower;
    y_sat = (y_sel > COORD_MAX) ? COORD_MAX : y_sel;
  end

  assign btn   = cmd.pass1 ? idx : bsel;
  assign xb    = XB_W'(btn) + XB_W'(1);
  assign prod  = PROD_W'(xb) * PROD_W'(x_step);
  assign x_sat = (prod > PROD_W'(COORD_MAX)) ? COORD_MAX : prod[COORD_W-1:0];

  assign bsum    = (BTN_W+1)'(bsel) + (BTN_W+1)'(STEP_MOD);
  assign rd_addr = (cmd.pass1 && !sts.idx_last) ? idx + BTN_W'(1) : '0;

  assign held    = cmd.pass1 && owner_vld[idx];
  assign pop_ptr = free_count - CNT_W'(1);
  assign pop_id  = free_stack[pop_ptr[SLOT_W-1:0]];
  assign pop     = cmd.pass2 && buttons_r[bsel] && !owner_vld[bsel] && (free_count != '0);

  assign emit_vec = con | ~rsent;
  assign emit_cur = emit_vec[slot];
  assign out_busy = report_valid && report_stall;
  assign load_out = cmd.report && emit_cur && !out_busy;

  always_comb begin
    more = 1'b0;
    for (int k = 0; k < MAX_CONTACTS; k++) begin
      if (SLOT_W'(k) > slot) more = more | emit_vec[k];
    end
  end

  always_comb begin
    sts.idx_last    = (idx == BTN_W'(NUM_BUTTONS - 1));
    sts.stack_empty = (free_count == '0);
    sts.slot_last   = (slot == SLOT_W'(MAX_CONTACTS - 1));
    sts.report_hold = emit_cur && out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height_lower  <= HEIGHT_LOWER_RST;
      height_center <= HEIGHT_CENTER_RST;
      height_upper  <= HEIGHT_UPPER_RST;
      x_step        <= X_STEP_RST;
      idx           <= '0;
      bsel          <= '0;
      slot          <= '0;
      owner_vld     <= '0;
      free_count    <= CNT_W'(MAX_CONTACTS);
      con           <= '0;
      rsent         <= '1;
      report_valid  <= 1'b0;
      for (int k = 0; k < MAX_CONTACTS; k++) begin
        free_stack[k] <= ID_W'(MAX_CONTACTS - 1 - k);
        cx[k]         <= '0;
        cy[k]         <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (cfg_reg_t'(wr_index))
          REG_HEIGHT_LOWER:  height_lower  <= wr_data;
          REG_HEIGHT_CENTER: height_center <= wr_data;
          REG_HEIGHT_UPPER:  height_upper  <= wr_data;
          REG_X_STEP:        x_step        <= wr_data[XSTEP_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        idx  <= '0;
        bsel <= '0;
        slot <= '0;
      end else if (cmd.pass1 || cmd.pass2) begin
        idx <= sts.idx_last ? '0 : idx + BTN_W'(1);
      end

      if (cmd.pass2) begin
        bsel <= (bsum >= (BTN_W+1)'(NUM_BUTTONS)) ?
                BTN_W'(bsum - (BTN_W+1)'(NUM_BUTTONS)) : BTN_W'(bsum);
      end

      // release pass: refresh held contacts, free released ones
      if (held) begin
        if (buttons_r[idx]) begin
          con[owner_rdata[SLOT_W-1:0]] <= 1'b1;
          cx[owner_rdata[SLOT_W-1:0]]  <= x_sat;
          cy[owner_rdata[SLOT_W-1:0]]  <= y_r;
        end else begin
          if (free_count < CNT_W'(MAX_CONTACTS)) begin
            free_stack[free_count[SLOT_W-1:0]] <= owner_rdata;
            free_count <= free_count + CNT_W'(1);
          end
          con[owner_rdata[SLOT_W-1:0]] <= 1'b0;
          cx[owner_rdata[SLOT_W-1:0]]  <= '0;
          cy[owner_rdata[SLOT_W-1:0]]  <= '0;
          owner_vld[idx] <= 1'b0;
        end
      end

      // assign pass: pop an id for a new press
      if (pop) begin
        free_count            <= pop_ptr;
        owner_vld[bsel]       <= 1'b1;
        con[pop_id[SLOT_W-1:0]] <= 1'b1;
        cx[pop_id[SLOT_W-1:0]]  <= x_sat;
        cy[pop_id[SLOT_W-1:0]]  <= y_r;
      end

      if (cmd.report && !sts.report_hold) begin
        slot <= sts.slot_last ? '0 : slot + SLOT_W'(1);
      end
      if (load_out) rsent[slot] <= !con[slot];

      if (load_out)           report_valid <= 1'b1;
      else if (!report_stall) report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buttons_r <= buttons;
      y_r       <= y_sat;
    end
    if (pop) owner_mem[bsel] <= pop_id;
    owner_rdata <= owner_mem[rd_addr];
    if (load_out) begin
      contact_count <= COUNT_W'(MAX_CONTACTS) - COUNT_W'(free_count);
      touch_id      <= ID_W'(slot);
      tip_down      <= con[slot];
      pos_x         <= cx[slot];
      pos_y         <= cy[slot];
      last          <= !more;
    end
  end

  a_free_count_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(MAX_CONTACTS))
    else $error("free id count above contact limit");

  a_on_matches_stack: assert property (@(posedge clk) disable iff (rst)
    $countones(con) == MAX_CONTACTS - int'(free_count))
    else $error("touching contacts disagree with free stack depth");

  a_owner_matches_stack: assert property (@(posedge clk) disable iff (rst)
    $countones(owner_vld) == MAX_CONTACTS - int'(free_count))
    else $error("owned buttons disagree with free stack depth");

  a_no_emit_on_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd.report |=> !$rose(report_valid) || $past(load_out))
    else $error("report raised outside the report walk");

endmodule

@@ sv/button_to_touch_contact_mapper.sv @@
// Top level of the button to touch contact mapper: controller plus datapath.
// Depends on bttcm_pkg, bttcm_ctrl and bttcm_dp.
//
//   channel  | handshake                  | payload
//   scan     | scan_valid / scan_stall    | buttons, center_pin_low, upper_pin_low
//   report   | report_valid / report_stall| contact_count, touch_id, tip_down,
//            |                            | pos_x, pos_y, last
//   config   | wr_en                      | wr_index, wr_data
//
// A scan runs an accept step, the release pass over all NUM_BUTTONS buttons,
// the assign pass (ends once the free stack runs dry or every button is
// visited) and the report walk over all MAX_CONTACTS slots.
// The report walk holds on a pending transaction while report_stall is high.
// The last transaction may still wait in the output register while the next
// scan is taken. Synchronous reset; no clearing pass is needed.
`timescale 1ns / 1ps

module button_to_touch_contact_mapper #(
  parameter int NUM_BUTTONS  = 28,
  parameter int MAX_CONTACTS = 10,
  parameter int SCAN_STRIDE  = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                scan_valid,
  output logic                                scan_stall,
  input  logic [NUM_BUTTONS-1:0]              buttons,
  input  logic                                center_pin_low,
  input  logic                                upper_pin_low,
  input  logic                                wr_en,
  input  logic [bttcm_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [bttcm_pkg::CFG_DATA_W-1:0]    wr_data,
  output logic                                report_valid,
  input  logic                                report_stall,
  output logic [bttcm_pkg::COUNT_W-1:0]       contact_count,
  output logic [bttcm_pkg::ID_W-1:0]          touch_id,
  output logic                                tip_down,
  output logic [bttcm_pkg::COORD_W-1:0]       pos_x,
  output logic [bttcm_pkg::COORD_W-1:0]       pos_y,
  output logic                                last
);
  import bttcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bttcm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  bttcm_dp #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .MAX_CONTACTS (MAX_CONTACTS),
    .SCAN_STRIDE  (SCAN_STRIDE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .buttons        (buttons),
    .center_pin_low (center_pin_low),
    .upper_pin_low  (upper_pin_low),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .report_valid   (report_valid),
    .report_stall   (report_stall),
    .contact_count  (contact_count),
    .touch_id       (touch_id),
    .tip_down       (tip_down),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .last           (last)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking bench for button_to_touch_contact_mapper: directed table, then random scans.
// Depends on bttcm_pkg and the mapper RTL; expected reports: typed rows or a built-in tracker.
`timescale 1ns / 1ps

module tb;
  import bttcm_pkg::*;

  localparam int NB       = 28;
  localparam int NC       = 10;
  localparam int STRIDE   = 3;
  localparam logic [ID_W-1:0] ID_NONE = 4'd15;
  localparam int SETTLE   = 120;
  localparam int PHASES   = 6;
  localparam int PHASE_N  = 74;
  localparam int DIR_N    = 20;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ID_W-1:0]    id;
    logic               tip;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } report_t;

  typedef struct packed {
    logic [NB-1:0] btn;
    logic          cpl;
    logic          upl;
    logic          typed;
    logic          has_rep;
    report_t       rep;
  } dir_row_t;

  localparam report_t NO_REP = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic scan_valid = 1'b0;
  logic scan_stall;
  logic [NB-1:0] buttons = '0;
  logic center_pin_low = 1'b0;
  logic upper_pin_low = 1'b0;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic report_valid;
  logic report_stall = 1'b0;
  logic [COUNT_W-1:0] contact_count;
  logic [ID_W-1:0] touch_id;
  logic tip_down;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic last;

  button_to_touch_contact_mapper DUT (
    .clk(clk), .rst(rst),
    .scan_valid(scan_valid), .scan_stall(scan_stall),
    .buttons(buttons), .center_pin_low(center_pin_low), .upper_pin_low(upper_pin_low),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .report_valid(report_valid), .report_stall(report_stall),
    .contact_count(contact_count), .touch_id(touch_id), .tip_down(tip_down),
    .pos_x(pos_x), .pos_y(pos_y), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // contact tracker state
  logic [COORD_W-1:0] h_lower, h_center, h_upper;
  logic [XSTEP_W-1:0] xstep;
  logic [ID_W-1:0]    owner [NB];
  logic [ID_W-1:0]    free_ids [NC];
  int unsigned        nfree;
  logic               touching [NC];
  logic [COORD_W-1:0] cx [NC];
  logic [COORD_W-1:0] cy [NC];
  logic               rel_sent [NC];

  report_t scan_reports [$];
  report_t expected_reports [$];
  int errors = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int stall_left = 0;
  report_t got, want;
  dir_row_t dir_rows [DIR_N];

  function automatic logic [COORD_W-1:0] clamp_coord(input int unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v[COORD_W-1:0];
  endfunction

  function automatic void reset_tracker();
    h_lower  = HEIGHT_LOWER_RST;
    h_center = HEIGHT_CENTER_RST;
    h_upper  = HEIGHT_UPPER_RST;
    xstep    = X_STEP_RST;
    for (int i = 0; i < NB; i++) owner[i] = ID_NONE;
    for (int i = 0; i < NC; i++) begin
      free_ids[i] = ID_W'(NC - 1 - i);
      touching[i] = 1'b0;
      cx[i] = '0;
      cy[i] = '0;
      rel_sent[i] = 1'b1;
    end
    nfree = NC;
  endfunction

  function automatic void track_scan(input logic [NB-1:0] b, input logic c, input logic u);
    logic [COORD_W-1:0] y;
    logic [ID_W-1:0] id;
    int bb, n, last_id;
    logic emit [NC];
    report_t rep;
    scan_reports.delete();
    if (c) y = clamp_coord(32'(h_center));
    else if (u) y = clamp_coord(32'(h_upper));
    else y = clamp_coord(32'(h_lower));
    // release pass
    for (int i = 0; i < NB; i++) begin
      id = owner[i];
      if (id != ID_NONE) begin
        if (b[i]) begin
          touching[id] = 1'b1;
          cx[id] = clamp_coord((i + 1) * xstep);
          cy[id] = y;
        end else begin
          if (nfree < NC) begin
            free_ids[nfree] = id;
            nfree++;
          end
          touching[id] = 1'b0;
          cx[id] = '0;
          cy[id] = '0;
          owner[i] = ID_NONE;
        end
      end
    end
    // assign pass, stride order, stops once the stack is dry
    for (int i = 0; i < NB && nfree > 0; i++) begin
      bb = (STRIDE * i) % NB;
      if (b[bb] && owner[bb] == ID_NONE) begin
        nfree--;
        id = free_ids[nfree];
        owner[bb] = id;
        touching[id] = 1'b1;
        cx[id] = clamp_coord((bb + 1) * xstep);
        cy[id] = y;
      end
    end
    n = 0;
    for (int i = 0; i < NC; i++) if (touching[i]) n++;
    last_id = -1;
    for (int i = 0; i < NC; i++) begin
      emit[i] = 1'b0;
      if (touching[i]) begin
        rel_sent[i] = 1'b0;
        emit[i] = 1'b1;
      end else if (!rel_sent[i]) begin
        rel_sent[i] = 1'b1;
        emit[i] = 1'b1;
      end
      if (emit[i]) last_id = i;
    end
    for (int i = 0; i < NC; i++) begin
      if (emit[i]) begin
        rep.count = COUNT_W'(n);
        rep.id    = ID_W'(i);
        rep.tip   = touching[i];
        rep.x     = cx[i];
        rep.y     = cy[i];
        rep.last  = (i == last_id);
        scan_reports.push_back(rep);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned e,
                                      input int unsigned a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  // report side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst && report_valid && !report_stall) begin
      got = {contact_count, touch_id, tip_down, pos_x, pos_y, last};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got id %0d count %0d",
                 $time, got.id, got.count);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("contact_count", 32'(want.count), 32'(got.count));
        check_field("touch_id", 32'(want.id), 32'(got.id));
        check_field("tip_down", 32'(want.tip), 32'(got.tip));
        check_field("pos_x", 32'(want.x), 32'(got.x));
        check_field("pos_y", 32'(want.y), 32'(got.y));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
    if (stall_left != 0) begin
      report_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rx_quiet && $urandom_range(0, 9) < 3) begin
      report_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
    end else begin
      report_stall <= 1'b0;
    end
  end

  task automatic send_scan(input logic [NB-1:0] b, input logic c, input logic u);
    int gap, r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 4);
    else gap = $urandom_range(15, 60);
    if (gap > 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_valid <= 1'b1;
    buttons <= b;
    center_pin_low <= c;
    upper_pin_low <= u;
    @(posedge clk);
    while (scan_stall) @(posedge clk);
    track_scan(b, c, u);
  endtask

  task automatic wait_drained();
    scan_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    wr_en <= 1'b1;
    wr_index <= r;
    wr_data <= v;
    unique case (r)
      REG_HEIGHT_LOWER:  h_lower = v;
      REG_HEIGHT_CENTER: h_center = v;
      REG_HEIGHT_UPPER:  h_upper = v;
      REG_X_STEP:        xstep = v[XSTEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] ce,
                                input logic [CFG_DATA_W-1:0] up, input logic [CFG_DATA_W-1:0] st);
    write_reg(REG_HEIGHT_LOWER, lo);
    write_reg(REG_HEIGHT_CENTER, ce);
    write_reg(REG_HEIGHT_UPPER, up);
    write_reg(REG_X_STEP, st);
    wr_en <= 1'b0;
  endtask

  initial begin
    logic [NB-1:0] held;
    logic c, u;
    int r, nb;
    dir_rows = '{
      {28'h0000001, 1'b0, 1'b0, 1'b1, 1'b1, {4'd1, 4'd0, 1'b1, 14'd344, 14'd9000, 1'b1}},
      {28'h0000000, 1'b0, 1'b0, 1'b1, 1'b1, {4'd0, 4'd0, 1'b0, 14'd0, 14'd0, 1'b1}},
      {28'h0000000, 1'b0, 1'b0, 1'b1, 1'b0, NO_REP},
      {28'h8000000, 1'b1, 1'b0, 1'b1, 1'b1, {4'd1, 4'd0, 1'b1, 14'd9632, 14'd5000, 1'b1}},
      {28'h8000000, 1'b0, 1'b1, 1'b1, 1'b1, {4'd1, 4'd0, 1'b1, 14'd9632, 14'd1000, 1'b1}},
      {28'h8000000, 1'b1, 1'b1, 1'b1, 1'b1, {4'd1, 4'd0, 1'b1, 14'd9632, 14'd5000, 1'b1}},
      {28'h0000000, 1'b0, 1'b0, 1'b1, 1'b1, {4'd0, 4'd0, 1'b0, 14'd0, 14'd0, 1'b1}},
      {28'hFFFFFFF, 1'b0, 1'b1, 1'b0, 1'b0, NO_REP},
      {28'hFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'hFFFFFFE, 1'b0, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'hFFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'h5555555, 1'b0, 1'b1, 1'b0, 1'b0, NO_REP},
      {28'hAAAAAAA, 1'b0, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'h0000000, 1'b0, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'h0000000, 1'b1, 1'b1, 1'b1, 1'b0, NO_REP},
      {28'h0000003, 1'b0, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'h0000006, 1'b0, 1'b1, 1'b0, 1'b0, NO_REP},
      {28'h0800000, 1'b1, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'hFFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_REP},
      {28'h0000000, 1'b0, 1'b0, 1'b0, 1'b0, NO_REP}
    };
    reset_tracker();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_N; k++) begin
      send_scan(dir_rows[k].btn, dir_rows[k].cpl, dir_rows[k].upl);
      if (!dir_rows[k].typed) begin
        foreach (scan_reports[j]) expected_reports.push_back(scan_reports[j]);
      end else if (dir_rows[k].has_rep) begin
        expected_reports.push_back(dir_rows[k].rep);
      end
    end

    held = '0;
    for (int ph = 1; ph <= PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      case (ph)
        1: apply_settings(14'd0, 14'd0, 14'd0, 14'd0);
        2: apply_settings(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h01FF);
        3: apply_settings(14'd10000, 14'd10000, 14'd10000, 14'd357);
        default: apply_settings(CFG_DATA_W'($urandom_range(0, 10000)),
                                CFG_DATA_W'($urandom_range(0, 16383)),
                                CFG_DATA_W'($urandom_range(0, 10000)),
                                CFG_DATA_W'($urandom_range(0, 511)));
      endcase
      tx_quiet = (ph == 2);
      rx_quiet = (ph == 2 || ph == 5);
      for (int k = 0; k < PHASE_N; k++) begin
        if (ph == 3 && k == 30) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 70) begin
          nb = $urandom_range(1, 3);
          repeat (nb) held = held ^ (28'd1 << $urandom_range(0, NB - 1));
        end else if (r < 80) held = NB'($urandom());
        else if (r < 85) held = '0;
        else if (r < 90) held = '1;
        else if (r < 95) held = held | NB'($urandom() & $urandom());
        else held = held & NB'($urandom());
        c = ($urandom_range(0, 2) == 0);
        u = 1'($urandom_range(0, 1));
        send_scan(held, c, u);
        foreach (scan_reports[j]) expected_reports.push_back(scan_reports[j]);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
